// ===== rtl/core/eid_pkg.sv =====
// Shared types, codes and constants of the invalidation directory.
`timescale 1ns / 1ps
package eid_pkg;

  localparam int SITES_DEF = 8;   // default number of sites
  localparam int ID_W      = 3;   // site id width
  localparam int OP_W      = 3;
  localparam int KIND_W    = 3;
  localparam int MAX_RES   = 16;  // messages kept per transaction
  localparam int CNT_W     = 5;
  localparam int SWP_MAX   = 8;   // site ids reachable through a 3-bit id

  typedef enum logic [OP_W-1:0] {
    OP_REG    = 3'd0,
    OP_DEREG  = 3'd1,
    OP_RDINV  = 3'd2,
    OP_WREQ   = 3'd3,
    OP_WDONE  = 3'd4,
    OP_FAIL   = 3'd5,
    OP_SFAIL  = 3'd6,
    OP_RSVD   = 3'd7
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 3'd0,
    KIND_INV   = 3'd1,
    KIND_READ  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_FAIL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_FINISH,
    PH_READ,
    PH_INV,
    PH_WRITE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_INV_PREP,
    ST_INV,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic read_step;
    logic inv_prep;
    logic inv_step;
    logic write_step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    phase_t phase;
    logic   read_hit;
    logic   inv_hit;
    logic   slot_ok;
    logic   out_free;
    logic   sweep_last;
    logic   wc_nz;
    logic   rdr_zero;
  } sts_t;

endpackage

// ===== rtl/core/eid_ctrl.sv =====
// Sequencer for one event: decode, read sweep, invalidate sweep, token, finish.
`timescale 1ns / 1ps
module eid_ctrl import eid_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.phase)
          PH_READ:  state_nxt = ST_READ;
          PH_INV:   state_nxt = ST_INV_PREP;
          PH_WRITE: state_nxt = ST_WRITE;
          default:  state_nxt = ST_FINISH;
        endcase
      end
      ST_READ: begin
        if (!sts.read_hit || sts.slot_ok) begin
          cmd.read_step = 1'b1;
          if (sts.sweep_last) begin
            state_nxt = sts.wc_nz ? ST_INV_PREP : ST_FINISH;
          end
        end
      end
      ST_INV_PREP: begin
        cmd.inv_prep = 1'b1;
        state_nxt    = ST_INV;
      end
      ST_INV: begin
        if (!sts.inv_hit || sts.slot_ok) begin
          cmd.inv_step = 1'b1;
          if (sts.sweep_last) begin
            state_nxt = sts.rdr_zero ? ST_WRITE : ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        if (sts.slot_ok) begin
          cmd.write_step = 1'b1;
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/eid_datapath.sv =====
// Directory state, writer queue, message staging and output register.
`timescale 1ns / 1ps
module eid_datapath import eid_pkg::*; #(
  parameter int SITES = SITES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ID_W-1:0]   cfg_wr_data,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ID_W-1:0]   in_site,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [ID_W-1:0]   out_dest_site,
  output logic [KIND_W-1:0] out_kind,
  output logic              out_failed,
  output logic              out_last,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int CW  = $clog2(SITES + 1);
  localparam int NSW = (SITES < SWP_MAX) ? SITES : SWP_MAX;

  typedef logic [SITES-1:0] mask_t;

  mask_t             reg_r, reg_nxt, rdr_r, rdr_nxt;
  logic [ID_W-1:0]   q_r [SITES];
  logic [ID_W-1:0]   q_nxt [SITES];
  logic [CW-1:0]     wc_r, wc_nxt;
  logic              perm_r, perm_nxt;
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   site_r;
  logic              wv_r, wv_nxt;
  logic [ID_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_dest_r, pend_dest_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  logic              ov_r, ov_nxt;
  logic [ID_W-1:0]   od_r, od_nxt;
  kind_t             ok_r, ok_nxt;
  logic              ol_r, ol_nxt;
  logic              of_r, of_nxt;

  mask_t             site_bit, q0_bit, cfg_bit, rdr_clr;
  logic [SWP_MAX-1:0] reg8, rdr8;
  logic [SITES-1:0]  match, shift_en;
  logic              found, ev_ok, wc_nz, out_free, read_hit, inv_hit, sweep_last;
  logic              offer, load_out, do_shift;
  logic [ID_W-1:0]   msg_dest;
  kind_t             msg_kind;
  phase_t            phase;

  // Decode helpers
  assign site_bit   = mask_t'(1) << site_r;
  assign q0_bit     = mask_t'(1) << q_r[0];
  assign cfg_bit    = mask_t'(1) << cfg_wr_data;
  assign rdr_clr    = rdr_r & ~site_bit;
  assign ev_ok      = (int'(site_r) < SITES) && (op_r != OP_RSVD);
  assign wc_nz      = (wc_r != '0);
  assign out_free   = !ov_r || out_ready;
  assign sweep_last = (p_r == ID_W'(NSW - 1));
  assign read_hit   = reg8[p_r] && !(wv_r && (p_r == site_r));
  assign inv_hit    = rdr8[p_r];

  // Narrow views of the masks for the sweep
  always_comb begin
    reg8 = '0;
    rdr8 = '0;
    for (int i = 0; i < NSW; i++) begin
      reg8[i] = reg_r[i];
      rdr8[i] = rdr_r[i];
    end
  end

  // First queue entry holding the event's site, and the shift mask behind it
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < SITES; i++) begin
      match[i]    = (q_r[i] == site_r) && (CW'(i) < wc_r);
      acc         = acc | match[i];
      shift_en[i] = acc;
    end
    found = acc;
  end

  // Event handling, sweeps and message staging
  always_comb begin
    reg_nxt       = reg_r;
    rdr_nxt       = rdr_r;
    wc_nxt        = wc_r;
    perm_nxt      = perm_r;
    wv_nxt        = wv_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_dest_nxt = pend_dest_r;
    pend_kind_nxt = pend_kind_r;
    ov_nxt        = ov_r && !out_ready;
    od_nxt        = od_r;
    ok_nxt        = ok_r;
    ol_nxt        = ol_r;
    of_nxt        = of_r;
    q_nxt         = q_r;
    offer         = 1'b0;
    load_out      = 1'b0;
    do_shift      = 1'b0;
    msg_dest      = site_r;
    msg_kind      = KIND_NONE;
    phase         = PH_FINISH;

    if (cmd.accept) begin
      cnt_nxt = '0;
    end

    // Decode one event and update the directory
    if (cmd.exec && ev_ok) begin
      if (perm_r) begin
        if (op_r != OP_SFAIL) begin
          offer    = 1'b1;
          msg_kind = KIND_FAIL;
        end
      end else begin
        case (op_t'(op_r))
          OP_REG: begin
            reg_nxt = reg_r | site_bit;
            if (!wc_nz) begin
              rdr_nxt  = rdr_r | site_bit;
              offer    = 1'b1;
              msg_kind = KIND_READ;
            end
          end
          OP_DEREG, OP_SFAIL: begin
            if ((rdr_r == '0) && wc_nz && (q_r[0] == site_r)) begin
              rdr_nxt  = '0;
              wc_nxt   = '0;
              perm_nxt = 1'b1;
            end else begin
              reg_nxt = reg_r & ~site_bit;
              if (found) begin
                do_shift = 1'b1;
                wc_nxt   = wc_r - CW'(1);
              end
              if ((rdr_r & site_bit) != '0) begin
                rdr_nxt = rdr_clr;
                if (rdr_clr == '0) begin
                  if (wc_nxt != '0) begin
                    phase = PH_WRITE;
                  end else begin
                    phase  = PH_READ;
                    wv_nxt = 1'b0;
                  end
                end
              end
            end
          end
          OP_RDINV: begin
            if ((rdr_r & site_bit) != '0) begin
              rdr_nxt = rdr_clr;
              if (rdr_clr == '0) begin
                if (wc_nz) begin
                  phase = PH_WRITE;
                end else begin
                  phase  = PH_READ;
                  wv_nxt = 1'b0;
                end
              end
            end
          end
          OP_WREQ: begin
            if (wc_r < CW'(SITES)) begin
              for (int i = 0; i < SITES; i++) begin
                if (CW'(i) == wc_r) q_nxt[i] = site_r;
              end
              wc_nxt = wc_r + CW'(1);
              if (!wc_nz) phase = PH_INV;
            end
          end
          OP_WDONE: begin
            if (wc_nz && (q_r[0] == site_r)) begin
              do_shift = 1'b1;
              wc_nxt   = wc_r - CW'(1);
              phase    = PH_READ;
              wv_nxt   = 1'b1;
            end
          end
          OP_FAIL: begin
            rdr_nxt  = '0;
            wc_nxt   = '0;
            perm_nxt = 1'b1;
          end
          default: ;
        endcase
      end
    end

    if (cmd.exec) begin
      p_nxt = '0;
    end

    // Shift the queue down over the removed entry
    if (do_shift) begin
      for (int i = 0; i < SITES - 1; i++) begin
        if (shift_en[i] || (op_r == OP_WDONE)) q_nxt[i] = q_r[i + 1];
      end
    end

    // Read token sweep over registered sites
    if (cmd.read_step) begin
      if (read_hit) begin
        offer    = 1'b1;
        msg_dest = p_r;
        msg_kind = KIND_READ;
      end
      if (sweep_last) rdr_nxt = rdr_r | reg_r;
      else            p_nxt   = p_r + ID_W'(1);
    end

    // Drop the head writer from the readers
    if (cmd.inv_prep) begin
      rdr_nxt = rdr_r & ~q0_bit;
      p_nxt   = '0;
    end

    // Invalidate sweep over valid readers
    if (cmd.inv_step) begin
      if (inv_hit) begin
        offer    = 1'b1;
        msg_dest = p_r;
        msg_kind = KIND_INV;
      end
      if (!sweep_last) p_nxt = p_r + ID_W'(1);
    end

    if (cmd.write_step) begin
      offer    = 1'b1;
      msg_dest = q_r[0];
      msg_kind = KIND_WRITE;
    end

    // Stage a message one behind so the final one can be marked
    if (offer && (cnt_r < CNT_W'(MAX_RES))) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (pend_v_r) begin
        load_out = 1'b1;
        od_nxt   = pend_dest_r;
        ok_nxt   = pend_kind_r;
        ol_nxt   = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_dest_nxt = msg_dest;
      pend_kind_nxt = msg_kind;
    end

    // Close the transaction with the staged message or a none reply
    if (cmd.finish) begin
      load_out   = 1'b1;
      od_nxt     = pend_v_r ? pend_dest_r : site_r;
      ok_nxt     = pend_v_r ? pend_kind_r : KIND_NONE;
      ol_nxt     = 1'b1;
      pend_v_nxt = 1'b0;
    end

    // Capture the failed flag with each message
    if (load_out) begin
      ov_nxt = 1'b1;
      of_nxt = perm_r;
    end

    // Re-seed the directory on a home site write
    if (cfg_wr_en) begin
      reg_nxt  = cfg_bit;
      rdr_nxt  = cfg_bit;
      wc_nxt   = '0;
      perm_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r    <= mask_t'(1);
      rdr_r    <= mask_t'(1);
      wc_r     <= '0;
      perm_r   <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
      cnt_r    <= '0;
      p_r      <= '0;
      wv_r     <= 1'b0;
    end else begin
      reg_r    <= reg_nxt;
      rdr_r    <= rdr_nxt;
      wc_r     <= wc_nxt;
      perm_r   <= perm_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
      cnt_r    <= cnt_nxt;
      p_r      <= p_nxt;
      wv_r     <= wv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_op;
      site_r <= in_site;
    end
    pend_dest_r <= pend_dest_nxt;
    pend_kind_r <= pend_kind_nxt;
    od_r        <= od_nxt;
    ok_r        <= ok_nxt;
    ol_r        <= ol_nxt;
    of_r        <= of_nxt;
    q_r         <= q_nxt;
  end

  assign out_valid     = ov_r;
  assign out_dest_site = od_r;
  assign out_kind      = ok_r;
  assign out_failed    = of_r;
  assign out_last      = ol_r;

  always_comb begin
    sts            = '0;
    sts.phase      = phase;
    sts.read_hit   = read_hit;
    sts.inv_hit    = inv_hit;
    sts.slot_ok    = !pend_v_r || out_free;
    sts.out_free   = out_free;
    sts.sweep_last = sweep_last;
    sts.wc_nz      = wc_nz;
    sts.rdr_zero   = (rdr_r == '0);
  end

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CW'(SITES)) else $error("writer count beyond queue depth");
  a_rdr_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (rdr_r & ~reg_r) == '0) else $error("reader not registered");
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    perm_r |-> (rdr_r == '0 && wc_r == '0)) else $error("failed entity holds state");
  a_finish_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (!pend_v_r && ov_r && ol_r)) else $error("final message not delivered");

endmodule

// ===== rtl/core/eager_invalidation_directory_core.sv =====
// Sequence per transaction: idle, decode and finish, with a read sweep and an invalidate
// sweep over the sites, a step to prepare the invalidate sweep and one for a write token.
// Transactions are handled one at a time: a new one is accepted only when idle.
// Results leave through an output register, so the last result may wait for out_ready.
// Reset (rst_n, synchronous, low): home site 0 registered and reader, queue empty.
`timescale 1ns / 1ps
module eager_invalidation_directory_core import eid_pkg::*; #(
  parameter int SITES = SITES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [ID_W-1:0]   cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ID_W-1:0]   in_site,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_dest_site,
  output logic [KIND_W-1:0] out_kind,
  output logic              out_failed,
  output logic              out_last
);

  cmd_t cmd;
  sts_t sts;

  eid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eid_datapath #(.SITES(SITES)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_op         (in_op),
    .in_site       (in_site),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_dest_site (out_dest_site),
    .out_kind      (out_kind),
    .out_failed    (out_failed),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
